FILE: rtl/core/pwst_pkg.sv
`timescale 1ns / 1ps

package pwst_pkg;

    localparam int FRAME_BITS = 32;
    localparam int CNT_W      = 8;
    localparam int WORD_W     = 32;
    localparam int TXBL_W     = 6;
    localparam int IDX_W      = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [IDX_W-1:0] {
        REG_BIT_TICKS       = 3'd0,
        REG_ONE_HIGH_TICKS  = 3'd1,
        REG_ZERO_HIGH_TICKS = 3'd2,
        REG_GAP_TICKS       = 3'd3,
        REG_RESYNC_TICKS    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] bit_ticks;
        logic [CNT_W-1:0] one_high_ticks;
        logic [CNT_W-1:0] zero_high_ticks;
        logic [CNT_W-1:0] gap_ticks;
        logic [CNT_W-1:0] resync_ticks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        bit_ticks:       8'd20,
        one_high_ticks:  8'd5,
        zero_high_ticks: 8'd15,
        gap_ticks:       8'd100,
        resync_ticks:    8'd50
    };

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_rx_res;

    typedef struct packed {
        logic line;
        logic loaded;
    } t_tx_res;

endpackage

FILE: rtl/core/pulse_width_serial_transceiver.sv
`timescale 1ns / 1ps
// Pulse-width one-wire serial transceiver.
// Each input word on s_axis is one timer tick: the sampled receive line level
// and the 32-bit word offered for transmission. Each accepted word yields
// exactly one output word on m_axis carrying the transmit line level for that
// tick, the received word with its valid flag, and the tx load flag.
// The result appears in the output register on m_axis in the cycle after the
// input word is accepted. Throughput: one tick per cycle while m_axis is not
// stalled; all receive and transmit state advances in a single pass of counter
// logic between the input handshake and the output register.
// When the downstream side stalls, the output register holds its word and
// s_axis_tready drops until it is taken; ticks are only advanced by accepted
// words, so no tick is lost or repeated.
// Configuration: the cfg channel is always ready; index 0..4 selects
// bit_ticks, one_high_ticks, zero_high_ticks, gap_ticks, resync_ticks; other
// indexes are ignored. Write only while the stream is idle.
// Reset (synchronous, active low) clears all counters and the output
// register and restores the default timing registers.

module pulse_width_serial_transceiver (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [39:0]                     s_axis_tdata,  // line_in, tx_word, zero pad
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [39:0]                     m_axis_tdata,  // line_out, rx_word, rx_valid,
                                                           // tx_loaded, zero pad
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pwst_pkg::IDX_W-1:0]      i_cfg_index,
    input  logic [pwst_pkg::CNT_W-1:0]      i_cfg_data
);

    pwst_pkg::t_cfg     r_cfg;
    pwst_pkg::t_rx_res  rx_res;
    pwst_pkg::t_tx_res  tx_res;
    logic               step;
    logic               r_out_valid;
    logic [34:0]        r_out;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pwst_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pwst_pkg::REG_BIT_TICKS:       r_cfg.bit_ticks       <= i_cfg_data;
                pwst_pkg::REG_ONE_HIGH_TICKS:  r_cfg.one_high_ticks  <= i_cfg_data;
                pwst_pkg::REG_ZERO_HIGH_TICKS: r_cfg.zero_high_ticks <= i_cfg_data;
                pwst_pkg::REG_GAP_TICKS:       r_cfg.gap_ticks       <= i_cfg_data;
                pwst_pkg::REG_RESYNC_TICKS:    r_cfg.resync_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pwst_rx u_rx (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (step),
        .i_line         (s_axis_tdata[0]),
        .i_resync_ticks (r_cfg.resync_ticks),
        .o_res          (rx_res)
    );

    pwst_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (step),
        .i_word  (s_axis_tdata[32:1]),
        .i_cfg   (r_cfg),
        .o_res   (tx_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (step) begin
                r_out_valid <= 1'b1;
                r_out       <= {tx_res.loaded, rx_res.valid, rx_res.word, tx_res.line};
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_out[33] |-> r_out[32:1] == '0)
        else $error("rx word nonzero without valid flag");

endmodule

FILE: rtl/core/pwst_rx.sv
`timescale 1ns / 1ps

module pwst_rx (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_line,
    input  logic [pwst_pkg::CNT_W-1:0] i_resync_ticks,
    output pwst_pkg::t_rx_res          o_res
);

    logic [pwst_pkg::CNT_W-1:0]  r_low_run, n_low_run;
    logic [pwst_pkg::CNT_W-1:0]  r_high_run, n_high_run;
    logic [pwst_pkg::CNT_W-1:0]  r_bits_left, n_bits_left;
    logic [pwst_pkg::WORD_W-1:0] r_shift, n_shift;
    logic                        r_prev_high, n_prev_high;
    logic [pwst_pkg::CNT_W-1:0]  low_inc;
    logic [pwst_pkg::CNT_W-1:0]  bl_dec;

    assign low_inc = (r_low_run == pwst_pkg::CNT_MAX) ? r_low_run : r_low_run + 8'd1;
    assign bl_dec  = r_bits_left - 8'd1;

    always_comb begin
        n_low_run   = r_low_run;
        n_high_run  = r_high_run;
        n_bits_left = r_bits_left;
        n_shift     = r_shift;
        n_prev_high = r_prev_high;
        o_res       = '0;
        if (!i_line) begin
            n_low_run = low_inc;
            if (!r_prev_high) begin
                n_high_run = '0;
            end else begin
                n_prev_high = 1'b0;
                if (low_inc == 8'd1) begin
                    n_bits_left = pwst_pkg::CNT_W'(pwst_pkg::FRAME_BITS);
                end else begin
                    n_shift     = {r_shift[pwst_pkg::WORD_W-2:0], (low_inc >= r_high_run)};
                    n_high_run  = '0;
                    n_low_run   = 8'd1;
                    n_bits_left = bl_dec;
                    if (bl_dec == '0) begin
                        o_res.valid = 1'b1;
                        o_res.word  = n_shift;
                    end
                end
            end
        end else begin
            n_prev_high = 1'b1;
            if (r_high_run >= i_resync_ticks) begin
                n_low_run   = '0;
                n_bits_left = pwst_pkg::CNT_W'(pwst_pkg::FRAME_BITS);
            end else begin
                n_high_run = r_high_run + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_run   <= '0;
            r_high_run  <= '0;
            r_bits_left <= '0;
            r_shift     <= '0;
            r_prev_high <= 1'b0;
        end else if (i_en) begin
            r_low_run   <= n_low_run;
            r_high_run  <= n_high_run;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
            r_prev_high <= n_prev_high;
        end
    end

    // a completed word is always closed by a falling edge
    a_valid_on_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.valid |-> !i_line && r_prev_high)
        else $error("rx word completed without a falling edge");

    a_valid_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.valid |=> r_bits_left == '0 && !r_prev_high)
        else $error("rx bit count not empty after word");

endmodule

FILE: rtl/core/pwst_tx.sv
`timescale 1ns / 1ps

module pwst_tx (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [pwst_pkg::WORD_W-1:0] i_word,
    input  pwst_pkg::t_cfg              i_cfg,
    output pwst_pkg::t_tx_res           o_res
);

    logic [pwst_pkg::CNT_W-1:0]  r_timer, n_timer;
    logic [pwst_pkg::TXBL_W-1:0] r_bits_left, n_bits_left;
    logic [pwst_pkg::WORD_W-1:0] r_shift, n_shift;
    logic                        r_active, n_active;
    logic                        r_cur_bit, n_cur_bit;
    logic [pwst_pkg::CNT_W-1:0]  timer_dec;
    logic [pwst_pkg::CNT_W-1:0]  thr;

    assign timer_dec = r_timer - 8'd1;
    assign thr       = r_cur_bit ? i_cfg.one_high_ticks : i_cfg.zero_high_ticks;

    always_comb begin
        n_timer     = r_timer;
        n_bits_left = r_bits_left;
        n_shift     = r_shift;
        n_active    = r_active;
        n_cur_bit   = r_cur_bit;
        o_res       = '0;
        if (r_active) begin
            n_timer = timer_dec;
            if (timer_dec == '0) begin
                if (r_bits_left == '0) begin
                    n_active = 1'b0;
                end else begin
                    n_bits_left = r_bits_left - 6'd1;
                    n_timer     = i_cfg.bit_ticks;
                    n_cur_bit   = r_shift[pwst_pkg::WORD_W-1];
                    n_shift     = {r_shift[pwst_pkg::WORD_W-2:0], 1'b0};
                end
            end else begin
                o_res.line = !(timer_dec > thr);
            end
        end else begin
            if (r_timer >= i_cfg.gap_ticks) begin
                n_active     = 1'b1;
                n_timer      = 8'd1;
                n_bits_left  = pwst_pkg::TXBL_W'(pwst_pkg::FRAME_BITS);
                n_shift      = i_word;
                o_res.loaded = 1'b1;
            end else begin
                n_timer = r_timer + 8'd1;
            end
            o_res.line = (n_timer >= i_cfg.one_high_ticks);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer     <= '0;
            r_bits_left <= '0;
            r_shift     <= '0;
            r_active    <= 1'b0;
            r_cur_bit   <= 1'b0;
        end else if (i_en) begin
            r_timer     <= n_timer;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
            r_active    <= n_active;
            r_cur_bit   <= n_cur_bit;
        end
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_bits_left == '0)
        else $error("tx idle with bits pending");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.loaded |=> r_active && r_timer == 8'd1)
        else $error("tx load did not start a frame");

endmodule

FILE: tb/sv/pulse_width_serial_transceiver_tb.sv
`timescale 1ns / 1ps

module pulse_width_serial_transceiver_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_TICKS  = 100;

    typedef struct packed {
        pwst_pkg::t_tx_res tx;
        pwst_pkg::t_rx_res rx;
    } t_tick_out;

    class transceiver_scoreboard;
        pwst_pkg::t_cfg timing;
        bit [7:0]  low_run, high_run, rx_left, tx_timer;
        bit [31:0] rx_sr, tx_sr;
        bit        prev_high, tx_active, tx_bit;
        bit [5:0]  tx_left;
        t_tick_out pending[$];
        int        errors, words_rx, loads;

        function new();
            timing = pwst_pkg::CFG_RESET;
        endfunction

        function void set_reg(logic [pwst_pkg::IDX_W-1:0] idx,
                              logic [pwst_pkg::CNT_W-1:0] val);
            case (idx)
                pwst_pkg::REG_BIT_TICKS:       timing.bit_ticks = val;
                pwst_pkg::REG_ONE_HIGH_TICKS:  timing.one_high_ticks = val;
                pwst_pkg::REG_ZERO_HIGH_TICKS: timing.zero_high_ticks = val;
                pwst_pkg::REG_GAP_TICKS:       timing.gap_ticks = val;
                pwst_pkg::REG_RESYNC_TICKS:    timing.resync_ticks = val;
                default: ;
            endcase
        endfunction

        // advance one tick and queue the output word it produces
        function void take_tick(bit line, bit [31:0] word);
            t_tick_out r;
            bit [7:0]  thr;
            r = '0;
            if (!line) begin
                if (low_run != 8'hFF) low_run++;
                if (!prev_high) begin
                    high_run = 8'd0;
                end else begin
                    prev_high = 1'b0;
                    if (low_run == 8'd1) begin
                        rx_left = 8'(pwst_pkg::FRAME_BITS);
                    end else begin
                        rx_sr    = {rx_sr[30:0], (low_run >= high_run)};
                        high_run = 8'd0;
                        low_run  = 8'd1;
                        rx_left--;
                        if (rx_left == 8'd0) begin
                            r.rx.valid = 1'b1;
                            r.rx.word  = rx_sr;
                        end
                    end
                end
            end else begin
                prev_high = 1'b1;
                if (high_run >= timing.resync_ticks) begin
                    low_run = 8'd0;
                    rx_left = 8'(pwst_pkg::FRAME_BITS);
                end else begin
                    high_run++;
                end
            end

            if (tx_active) begin
                tx_timer--;
                if (tx_timer == 8'd0) begin
                    r.tx.line = 1'b0;
                    if (tx_left == 6'd0) begin
                        tx_active = 1'b0;
                        tx_timer  = 8'd0;
                    end else begin
                        tx_left--;
                        tx_timer = timing.bit_ticks;
                        tx_bit   = tx_sr[31];
                        tx_sr    = tx_sr << 1;
                    end
                end else begin
                    thr = tx_bit ? timing.one_high_ticks : timing.zero_high_ticks;
                    r.tx.line = (tx_timer <= thr);
                end
            end else begin
                if (tx_timer >= timing.gap_ticks) begin
                    tx_active   = 1'b1;
                    tx_timer    = 8'd1;
                    tx_left     = 6'(pwst_pkg::FRAME_BITS);
                    tx_sr       = word;
                    r.tx.loaded = 1'b1;
                end else begin
                    tx_timer++;
                end
                r.tx.line = (tx_timer >= timing.one_high_ticks);
            end
            pending.push_back(r);
        endfunction

        function void cmp(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h got %h", $time, field, exp_v, act_v);
            end
        endfunction

        // m_axis word: line_out, rx_word, rx_valid, tx_loaded from bit 0 up
        function void check_tick(logic [39:0] d);
            t_tick_out e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: output word with no tick outstanding, got %h", $time, d);
                return;
            end
            e = pending.pop_front();
            cmp("line_out", 32'(e.tx.line), 32'(d[0]));
            cmp("rx_word", e.rx.word, d[32:1]);
            cmp("rx_valid", 32'(e.rx.valid), 32'(d[33]));
            cmp("tx_loaded", 32'(e.tx.loaded), 32'(d[34]));
            if (e.rx.valid) words_rx++;
            if (e.tx.loaded) loads++;
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [39:0]                   s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [39:0]                   m_axis_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [pwst_pkg::IDX_W-1:0]    i_cfg_index = '0;
    logic [pwst_pkg::CNT_W-1:0]    i_cfg_data = '0;

    transceiver_scoreboard sb;
    int tx_idle_pct = 7;
    int rx_idle_pct = 72;
    int ticks_sent  = 0;
    int cycle_count = 0;

    pulse_width_serial_transceiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("pulse_width_serial_transceiver_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_tick(m_axis_tdata);
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_tick(bit line, bit [31:0] word);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, word, line};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_tick(line, word);
        ticks_sent++;
    endtask

    task automatic send_run(bit line, int n);
        repeat (n) send_tick(line, $urandom);
    endtask

    // resync preamble, then one arming cell and a bit per further cell
    task automatic send_frame(bit broken);
        int rs, hmax, cells, cut;
        rs    = int'(sb.timing.resync_ticks);
        hmax  = (rs == 0) ? 1 : ((rs < 4) ? rs : 4);
        cells = pwst_pkg::FRAME_BITS + 1;
        if ($urandom_range(0, 3) == 0) cells += $urandom_range(1, 3);
        cut = broken ? $urandom_range(1, cells - 1) : cells;
        send_run(1'b1, rs + 1 + $urandom_range(0, 2));
        for (int c = 0; c < cells; c++) begin
            if (c == cut) begin
                if ($urandom_range(0, 1)) send_run(1'b1, rs + 1);
                else break;
            end
            send_run(1'b0, $urandom_range(1, 4));
            send_run(1'b1, $urandom_range(1, hmax));
        end
    endtask

    task automatic send_noise();
        int runs;
        runs = $urandom_range(4, 16);
        repeat (runs) begin
            if ($urandom_range(0, 59) == 0) send_run(1'b0, $urandom_range(256, 300));
            else send_run(1'($urandom_range(0, 1)), $urandom_range(1, 8));
        end
    endtask

    task automatic write_reg(logic [pwst_pkg::IDX_W-1:0] idx,
                             logic [pwst_pkg::CNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_timing(logic [7:0] bt, logic [7:0] oh, logic [7:0] zh,
                                logic [7:0] gp, logic [7:0] rs);
        write_reg(pwst_pkg::REG_BIT_TICKS, bt);
        write_reg(pwst_pkg::REG_ONE_HIGH_TICKS, oh);
        write_reg(pwst_pkg::REG_ZERO_HIGH_TICKS, zh);
        write_reg(pwst_pkg::REG_GAP_TICKS, gp);
        write_reg(pwst_pkg::REG_RESYNC_TICKS, rs);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        bit [31:0] dwords[6];
        bit [23:0] dlines;
        int        start, pick;
        dwords = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555};
        dlines = 24'b0110_0011_1010_0100_1110_0010;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 24; i++) send_tick(dlines[i], dwords[i % 6]);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin tx_idle_pct = 7;  rx_idle_pct = 72; end
                1: begin tx_idle_pct = 72; rx_idle_pct = 7;  end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (phase > 0) settle();
            case (phase)
                1: apply_timing(8'd4, 8'd1, 8'd3, 8'd2, 8'd8);
                2: apply_timing(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                3: apply_timing(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                4: apply_timing(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
                5: begin
                    // unmapped index must leave the timing untouched
                    write_reg(pwst_pkg::REG_RESYNC_TICKS + 3'($urandom_range(1, 3)),
                              8'($urandom));
                    apply_timing(8'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
                                 8'($urandom_range(1, 8)), 8'($urandom_range(0, 20)),
                                 8'($urandom_range(5, 40)));
                end
                default: ;
            endcase
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) send_frame(1'b0);
                else if (pick < 72) send_frame(1'b1);
                else send_noise();
            end
        end
        settle();

        $display("Covered %0d ticks over six timing settings: %0d received words, %0d tx loads",
                 ticks_sent, sb.words_rx, sb.loads);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("pulse_width_serial_transceiver_tb passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("pulse_width_serial_transceiver_tb failed");
        end
        $finish;
    end

endmodule
